// ----- rtl/core/cpv_pkg.sv -----
// Shared constants for the contour point visibility core.
// Field widths, parameter defaults and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpv_pkg;

   localparam int COORD_BITS_DEF     = 13;
   localparam int TRIG_FRAC_BITS_DEF = 14;

   localparam int CENTER_W = 12;
   localparam int MODEL_W  = 12;
   localparam int NORM_W   = 31;
   localparam int SENSOR_W = 12;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_SENSOR0_X   = 3'd0;
   localparam csr_idx_type CSR_SENSOR0_Y   = 3'd1;
   localparam csr_idx_type CSR_SENSOR1_X   = 3'd2;
   localparam csr_idx_type CSR_SENSOR1_Y   = 3'd3;
   localparam csr_idx_type CSR_FACING_MODE = 3'd4;

   localparam logic MODE_BODY = 1'b0;
   localparam logic MODE_HEAD = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/contour_point_visibility_core.sv -----
// Contour point visibility core: rotate, round and place a model contour point,
// then test whether its rotated normal faces the selected sensor.
// Depends on cpv_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A transaction is taken at every clock edge with start high; busy never rises, so one
// point enters per cycle without pause. Each result leaves in order as a one-cycle
// rsp_valid strobe that the receiver cannot stall. The squared normal and distance
// terms and the squared inner product are wider than one multiplier, so they are built
// from partial products over several register stages before the final compare. Sensor
// positions and the facing mode are written through the csr_ port while no transaction
// is in flight; the user must keep to this, as the core does not enforce it.
module contour_point_visibility_core #(
   parameter int COORD_BITS     = cpv_pkg::COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = cpv_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire  logic                                  clock,
   input  wire  logic                                  reset,
   input  wire  logic                                  start,
   output       logic                                  busy,
   input  wire  logic        [cpv_pkg::CENTER_W-1:0]   req_center_x,
   input  wire  logic        [cpv_pkg::CENTER_W-1:0]   req_center_y,
   input  wire  logic signed [TRIG_FRAC_BITS+1:0]      req_rot_cos,
   input  wire  logic signed [TRIG_FRAC_BITS+1:0]      req_rot_sin,
   input  wire  logic                                  req_sensor_sel,
   input  wire  logic signed [cpv_pkg::MODEL_W-1:0]    req_model_x,
   input  wire  logic signed [cpv_pkg::MODEL_W-1:0]    req_model_y,
   input  wire  logic signed [cpv_pkg::NORM_W-1:0]     req_normal_x,
   input  wire  logic signed [cpv_pkg::NORM_W-1:0]     req_normal_y,
   input  wire  logic                                  req_last_point,
   output       logic                                  rsp_valid,
   output       logic signed [COORD_BITS:0]            rsp_contour_x,
   output       logic signed [COORD_BITS:0]            rsp_contour_y,
   output       logic                                  rsp_visible,
   output       logic                                  rsp_last_out,
   input  wire  logic                                  csr_we,
   input  wire  cpv_pkg::csr_idx_type                  csr_index,
   input  wire  logic        [cpv_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import cpv_pkg::*;

   localparam int TW     = TRIG_FRAC_BITS + 2;
   localparam int PP_W   = TW + MODEL_W;
   localparam int PS_W   = PP_W + 1;
   localparam int NP_W   = TW + NORM_W;
   localparam int NS_W   = NP_W + 1;
   localparam int PQ_W   = PS_W - TRIG_FRAC_BITS;
   localparam int VQ_W   = NS_W - TRIG_FRAC_BITS;
   localparam int OUT_W  = COORD_BITS + 1;
   localparam int SC_W   = ((PQ_W > OUT_W) ? PQ_W : OUT_W) + 1;
   localparam int D_W    = ((OUT_W > SENSOR_W + 1) ? OUT_W : SENSOR_W + 1) + 1;
   localparam int DD_W   = 2 * D_W + 1;
   localparam int VV_W   = 2 * VQ_W + 1;
   localparam int IPP_W  = VQ_W + D_W;
   localparam int IP_W   = IPP_W + 1;
   localparam int IPL_W  = IP_W / 2;
   localparam int IPH_W  = IP_W - IPL_W;
   localparam int IP2_W  = 2 * IP_W;
   localparam int LHS_W  = IP2_W + 5;
   localparam int VVL_W  = VV_W / 2;
   localparam int VVH_W  = VV_W - VVL_W;
   localparam int RHS_W  = VV_W + DD_W;
   localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
   localparam int STAGES = 9;

   localparam logic signed [SC_W-1:0]  SAT_LO = SC_W'(-(2 ** (COORD_BITS - 1)));
   localparam logic signed [SC_W-1:0]  SAT_HI = SC_W'((2 ** COORD_BITS) - 1);
   localparam logic signed [OUT_W-1:0] OUT_LO = OUT_W'(-(2 ** (COORD_BITS - 1)));
   localparam logic [TRIG_FRAC_BITS-1:0] TRIG_HALF = {1'b1, {(TRIG_FRAC_BITS-1){1'b0}}};

   function automatic logic [PQ_W-1:0] round_point(input logic [PS_W-1:0] t);
      logic [PQ_W-1:0]           q;
      logic [TRIG_FRAC_BITS-1:0] rem;
      logic                      up;
      q   = t[PS_W-1:TRIG_FRAC_BITS];
      rem = t[TRIG_FRAC_BITS-1:0];
      up  = (rem > TRIG_HALF) || ((rem == TRIG_HALF) && q[0]);
      return q + PQ_W'(up);
   endfunction

   function automatic logic [VQ_W-1:0] round_normal(input logic [NS_W-1:0] t);
      logic [VQ_W-1:0]           q;
      logic [TRIG_FRAC_BITS-1:0] rem;
      logic                      up;
      q   = t[NS_W-1:TRIG_FRAC_BITS];
      rem = t[TRIG_FRAC_BITS-1:0];
      up  = (rem > TRIG_HALF) || ((rem == TRIG_HALF) && q[0]);
      return q + VQ_W'(up);
   endfunction

   // configuration registers
   logic [SENSOR_W-1:0] sensor0_x_ff, sensor0_y_ff, sensor1_x_ff, sensor1_y_ff;
   logic                facing_mode_ff;

   logic                accept;
   logic [STAGES:1]     vld_ff, vld_in;
   logic                last_ff [1:STAGES];
   logic                last_in [1:STAGES];

   // stage 1: products
   logic signed [PP_W-1:0] p_cmx_ff, p_smy_ff, p_smx_ff, p_cmy_ff;
   logic signed [PP_W-1:0] p_cmx_in, p_smy_in, p_smx_in, p_cmy_in;
   logic signed [NP_W-1:0] n_cnx_ff, n_sny_ff, n_snx_ff, n_cny_ff;
   logic signed [NP_W-1:0] n_cnx_in, n_sny_in, n_snx_in, n_cny_in;
   logic [CENTER_W-1:0]    cx_ff [1:3];
   logic [CENTER_W-1:0]    cx_in [1:3];
   logic [CENTER_W-1:0]    cy_ff [1:3];
   logic [CENTER_W-1:0]    cy_in [1:3];
   logic [SENSOR_W-1:0]    sx_ff [1:3];
   logic [SENSOR_W-1:0]    sx_in [1:3];
   logic [SENSOR_W-1:0]    sy_ff [1:3];
   logic [SENSOR_W-1:0]    sy_in [1:3];

   // stage 2: rotation sums
   logic signed [PS_W-1:0] tx_ff, ty_ff, tx_in, ty_in;
   logic signed [NS_W-1:0] ux_ff, uy_ff, ux_in, uy_in;

   // stage 3: rounded values
   logic signed [PQ_W-1:0] qx_ff, qy_ff, qx_in, qy_in;
   logic signed [VQ_W-1:0] vx3_ff, vy3_ff, vx3_in, vy3_in;

   // stage 4: placed point and sensor offset
   logic signed [SC_W-1:0]  sum_x, sum_y;
   logic signed [OUT_W-1:0] px4_in, py4_in;
   logic signed [D_W-1:0]   dx_ff, dy_ff, dx_in, dy_in;
   logic signed [VQ_W-1:0]  vx4_ff, vy4_ff;

   // point carried from stage 4 to the output
   logic signed [OUT_W-1:0] px_ff [4:STAGES];
   logic signed [OUT_W-1:0] px_in [4:STAGES];
   logic signed [OUT_W-1:0] py_ff [4:STAGES];
   logic signed [OUT_W-1:0] py_in [4:STAGES];

   // stage 5: squares and inner product terms
   logic [D_W-1:0]           dxm, dym;
   logic [VQ_W-1:0]          vxm, vym;
   logic [2*D_W-1:0]         dx2_ff, dy2_ff, dx2_in, dy2_in;
   logic [2*VQ_W-1:0]        vx2_ff, vy2_ff, vx2_in, vy2_in;
   logic signed [IPP_W-1:0]  ipx_ff, ipy_ff, ipx_in, ipy_in;

   // stage 6: magnitudes and inner product
   logic [DD_W-1:0]         dd_ff, dd_in;
   logic [VV_W-1:0]         vv_ff, vv_in;
   logic signed [IP_W-1:0]  ip_ff, ip_in;

   // stage 7: partial products
   logic [IP_W-1:0]           ipm;
   logic [2*IPH_W-1:0]        hh_ff, hh_in;
   logic [IPH_W+IPL_W-1:0]    hl_ff, hl_in;
   logic [2*IPL_W-1:0]        ll_ff, ll_in;
   logic [VVH_W+DD_W-1:0]     vhd_ff, vhd_in;
   logic [VVL_W+DD_W-1:0]     vld_dd_ff, vld_dd_in;
   logic                      zero_ff  [7:STAGES];
   logic                      zero_in  [7:STAGES];
   logic                      ineg_ff  [7:STAGES];
   logic                      ineg_in  [7:STAGES];
   logic                      izero_ff [7:STAGES];
   logic                      izero_in [7:STAGES];

   // stage 8, 9: squared inner product and right side
   logic [IP2_W-1:0]  ip2_ff, ip2_in;
   logic [RHS_W-1:0]  rhs8_ff, rhs8_in, rhs9_ff;
   logic [LHS_W-1:0]  lhs_ff, lhs_in;

   // output
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                    rsp_vis_ff, rsp_vis_in;
   logic                    rsp_last_ff;
   logic                    gt, lt;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor0_x_ff   <= '0;
         sensor0_y_ff   <= '0;
         sensor1_x_ff   <= '0;
         sensor1_y_ff   <= '0;
         facing_mode_ff <= MODE_BODY;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SENSOR0_X:   sensor0_x_ff   <= csr_wdata[SENSOR_W-1:0];
            CSR_SENSOR0_Y:   sensor0_y_ff   <= csr_wdata[SENSOR_W-1:0];
            CSR_SENSOR1_X:   sensor1_x_ff   <= csr_wdata[SENSOR_W-1:0];
            CSR_SENSOR1_Y:   sensor1_y_ff   <= csr_wdata[SENSOR_W-1:0];
            CSR_FACING_MODE: facing_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      vld_in       = {vld_ff[STAGES-1:1], accept};
      rsp_valid_in = vld_ff[STAGES];
      last_in[1]   = req_last_point;
      for (int i = 2; i <= STAGES; i++) begin
         last_in[i] = last_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // stage 1
   always_comb begin
      p_cmx_in = req_rot_cos * req_model_x;
      p_smy_in = req_rot_sin * req_model_y;
      p_smx_in = req_rot_sin * req_model_x;
      p_cmy_in = req_rot_cos * req_model_y;
      n_cnx_in = req_rot_cos * req_normal_x;
      n_sny_in = req_rot_sin * req_normal_y;
      n_snx_in = req_rot_sin * req_normal_x;
      n_cny_in = req_rot_cos * req_normal_y;
      cx_in[1] = req_center_x;
      cy_in[1] = req_center_y;
      sx_in[1] = req_sensor_sel ? sensor1_x_ff : sensor0_x_ff;
      sy_in[1] = req_sensor_sel ? sensor1_y_ff : sensor0_y_ff;
      for (int i = 2; i <= 3; i++) begin
         cx_in[i] = cx_ff[i-1];
         cy_in[i] = cy_ff[i-1];
         sx_in[i] = sx_ff[i-1];
         sy_in[i] = sy_ff[i-1];
      end
   end

   // stage 2
   always_comb begin
      tx_in = PS_W'(p_cmx_ff) - PS_W'(p_smy_ff);
      ty_in = PS_W'(p_smx_ff) + PS_W'(p_cmy_ff);
      ux_in = NS_W'(n_cnx_ff) - NS_W'(n_sny_ff);
      uy_in = NS_W'(n_snx_ff) + NS_W'(n_cny_ff);
   end

   // stage 3
   always_comb begin
      qx_in  = round_point(tx_ff);
      qy_in  = round_point(ty_ff);
      vx3_in = round_normal(ux_ff);
      vy3_in = round_normal(uy_ff);
   end

   // stage 4: translate, saturate, offset to sensor
   always_comb begin
      sum_x = SC_W'(qx_ff) + SC_W'(cx_ff[3]);
      sum_y = SC_W'(qy_ff) + SC_W'(cy_ff[3]);
      if (sum_x < SAT_LO) begin
         px4_in = OUT_W'(SAT_LO);
      end else if (sum_x > SAT_HI) begin
         px4_in = OUT_W'(SAT_HI);
      end else begin
         px4_in = OUT_W'(sum_x);
      end
      if (sum_y < SAT_LO) begin
         py4_in = OUT_W'(SAT_LO);
      end else if (sum_y > SAT_HI) begin
         py4_in = OUT_W'(SAT_HI);
      end else begin
         py4_in = OUT_W'(sum_y);
      end
      dx_in = D_W'(sx_ff[3]) - D_W'(px4_in);
      dy_in = D_W'(sy_ff[3]) - D_W'(py4_in);
      px_in[4] = px4_in;
      py_in[4] = py4_in;
      for (int i = 5; i <= STAGES; i++) begin
         px_in[i] = px_ff[i-1];
         py_in[i] = py_ff[i-1];
      end
   end

   // stage 5
   always_comb begin
      dxm    = dx_ff[D_W-1] ? D_W'(-dx_ff) : D_W'(dx_ff);
      dym    = dy_ff[D_W-1] ? D_W'(-dy_ff) : D_W'(dy_ff);
      vxm    = vx4_ff[VQ_W-1] ? VQ_W'(-vx4_ff) : VQ_W'(vx4_ff);
      vym    = vy4_ff[VQ_W-1] ? VQ_W'(-vy4_ff) : VQ_W'(vy4_ff);
      dx2_in = dxm * dxm;
      dy2_in = dym * dym;
      vx2_in = vxm * vxm;
      vy2_in = vym * vym;
      ipx_in = vx4_ff * dx_ff;
      ipy_in = vy4_ff * dy_ff;
   end

   // stage 6
   always_comb begin
      dd_in = DD_W'(dx2_ff) + DD_W'(dy2_ff);
      vv_in = VV_W'(vx2_ff) + VV_W'(vy2_ff);
      ip_in = IP_W'(ipx_ff) + IP_W'(ipy_ff);
   end

   // stage 7: split the wide squares into partial products
   always_comb begin
      ipm         = ip_ff[IP_W-1] ? IP_W'(-ip_ff) : IP_W'(ip_ff);
      hh_in       = ipm[IP_W-1:IPL_W] * ipm[IP_W-1:IPL_W];
      hl_in       = ipm[IP_W-1:IPL_W] * ipm[IPL_W-1:0];
      ll_in       = ipm[IPL_W-1:0] * ipm[IPL_W-1:0];
      vhd_in      = vv_ff[VV_W-1:VVL_W] * dd_ff;
      vld_dd_in   = vv_ff[VVL_W-1:0] * dd_ff;
      zero_in[7]  = (dd_ff == '0) || (vv_ff == '0);
      ineg_in[7]  = ip_ff[IP_W-1];
      izero_in[7] = (ip_ff == '0);
      for (int i = 8; i <= STAGES; i++) begin
         zero_in[i]  = zero_ff[i-1];
         ineg_in[i]  = ineg_ff[i-1];
         izero_in[i] = izero_ff[i-1];
      end
   end

   // stage 8, 9
   always_comb begin
      ip2_in  = (IP2_W'(hh_ff) << (2 * IPL_W)) + (IP2_W'(hl_ff) << (IPL_W + 1))
              + IP2_W'(ll_ff);
      rhs8_in = (RHS_W'(vhd_ff) << VVL_W) + RHS_W'(vld_dd_ff);
      lhs_in  = (LHS_W'(ip2_ff) << 4) + (LHS_W'(ip2_ff) << 3) + LHS_W'(ip2_ff);
   end

   // output stage: facing decision
   always_comb begin
      gt = CMP_W'(lhs_ff) > CMP_W'(rhs9_ff);
      lt = CMP_W'(lhs_ff) < CMP_W'(rhs9_ff);
      if (zero_ff[STAGES]) begin
         rsp_vis_in = 1'b0;
      end else if (facing_mode_ff == MODE_HEAD) begin
         rsp_vis_in = !ineg_ff[STAGES] || lt;
      end else begin
         rsp_vis_in = !ineg_ff[STAGES] && !izero_ff[STAGES] && gt;
      end
   end

   always_ff @(posedge clock) begin
      p_cmx_ff  <= p_cmx_in;
      p_smy_ff  <= p_smy_in;
      p_smx_ff  <= p_smx_in;
      p_cmy_ff  <= p_cmy_in;
      n_cnx_ff  <= n_cnx_in;
      n_sny_ff  <= n_sny_in;
      n_snx_ff  <= n_snx_in;
      n_cny_ff  <= n_cny_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      last_ff   <= last_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      vx3_ff    <= vx3_in;
      vy3_ff    <= vy3_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      vx4_ff    <= vx3_ff;
      vy4_ff    <= vy3_ff;
      px_ff     <= px_in;
      py_ff     <= py_in;
      dx2_ff    <= dx2_in;
      dy2_ff    <= dy2_in;
      vx2_ff    <= vx2_in;
      vy2_ff    <= vy2_in;
      ipx_ff    <= ipx_in;
      ipy_ff    <= ipy_in;
      dd_ff     <= dd_in;
      vv_ff     <= vv_in;
      ip_ff     <= ip_in;
      hh_ff     <= hh_in;
      hl_ff     <= hl_in;
      ll_ff     <= ll_in;
      vhd_ff    <= vhd_in;
      vld_dd_ff <= vld_dd_in;
      zero_ff   <= zero_in;
      ineg_ff   <= ineg_in;
      izero_ff  <= izero_in;
      ip2_ff    <= ip2_in;
      rhs8_ff   <= rhs8_in;
      rhs9_ff   <= rhs8_ff;
      lhs_ff    <= lhs_in;
      rsp_x_ff    <= px_ff[STAGES];
      rsp_y_ff    <= py_ff[STAGES];
      rsp_vis_ff  <= rsp_vis_in;
      rsp_last_ff <= last_ff[STAGES];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_contour_x = rsp_x_ff;
   assign rsp_contour_y = rsp_y_ff;
   assign rsp_visible   = rsp_vis_ff;
   assign rsp_last_out  = rsp_last_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##10 rsp_valid)
      else $error("transaction did not produce a result after 10 cycles");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 10))
      else $error("result without a matching transaction");

   a_zero_hidden: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES] && zero_ff[STAGES]) |=> (rsp_valid && !rsp_visible))
      else $error("zero magnitude point marked visible");

   a_sat_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_contour_x >= OUT_LO) && (rsp_contour_y >= OUT_LO)))
      else $error("contour point below saturation floor");

endmodule

`default_nettype wire

// ----- dv/cpv_placement_checker.sv -----
// Scoreboard for the contour point visibility core: predicts the placed point and
// the facing decision for every accepted transaction and compares the result strobes.
// Depends on cpv_pkg.
`timescale 1ns / 1ps

module cpv_placement_checker #(
   parameter int COORD_BITS     = cpv_pkg::COORD_BITS_DEF,
   parameter int TRIG_FRAC_BITS = cpv_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic                                  busy,
   input  wire logic        [cpv_pkg::CENTER_W-1:0]   req_center_x,
   input  wire logic        [cpv_pkg::CENTER_W-1:0]   req_center_y,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]      req_rot_cos,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]      req_rot_sin,
   input  wire logic                                  req_sensor_sel,
   input  wire logic signed [cpv_pkg::MODEL_W-1:0]    req_model_x,
   input  wire logic signed [cpv_pkg::MODEL_W-1:0]    req_model_y,
   input  wire logic signed [cpv_pkg::NORM_W-1:0]     req_normal_x,
   input  wire logic signed [cpv_pkg::NORM_W-1:0]     req_normal_y,
   input  wire logic                                  req_last_point,
   input  wire logic                                  rsp_valid,
   input  wire logic signed [COORD_BITS:0]            rsp_contour_x,
   input  wire logic signed [COORD_BITS:0]            rsp_contour_y,
   input  wire logic                                  rsp_visible,
   input  wire logic                                  rsp_last_out,
   input  wire logic                                  csr_we,
   input  wire cpv_pkg::csr_idx_type                  csr_index,
   input  wire logic        [cpv_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                         mismatches,
   output int                                         pending,
   output int                                         points_checked,
   output int                                         visible_points
);

   import cpv_pkg::*;

   typedef struct packed {
      logic signed [COORD_BITS:0] x;
      logic signed [COORD_BITS:0] y;
      logic                       visible;
      logic                       last;
   } placement_type;

   typedef logic signed [127:0] sq_type;

   localparam logic [TRIG_FRAC_BITS-1:0] HALF_LSB = {1'b1, {(TRIG_FRAC_BITS-1){1'b0}}};

   placement_type       expected_placements[$];
   logic [SENSOR_W-1:0] sensor_x[2];
   logic [SENSOR_W-1:0] sensor_y[2];
   logic                facing;
   int                  fail_count = 0;
   int                  checked_count = 0;
   int                  visible_count = 0;

   // scale down by the trig fraction, round half to even
   function automatic longint round_trig(input longint t);
      longint                    q;
      logic [TRIG_FRAC_BITS-1:0] frac;
      q = t >>> TRIG_FRAC_BITS;
      frac = t[TRIG_FRAC_BITS-1:0];
      if (frac > HALF_LSB || (frac == HALF_LSB && q[0])) q = q + 1;
      return q;
   endfunction

   function automatic longint clamp_coord(input longint v);
      longint floor_v, ceil_v;
      floor_v = -(longint'(1) <<< (COORD_BITS - 1));
      ceil_v = (longint'(1) <<< COORD_BITS) - 1;
      if (v < floor_v) return floor_v;
      if (v > ceil_v) return ceil_v;
      return v;
   endfunction

   function automatic placement_type predict_placement(
      input logic        [CENTER_W-1:0]       cx_in,
      input logic        [CENTER_W-1:0]       cy_in,
      input logic signed [TRIG_FRAC_BITS+1:0] cos_in,
      input logic signed [TRIG_FRAC_BITS+1:0] sin_in,
      input logic                             sel,
      input logic signed [MODEL_W-1:0]        mx_in,
      input logic signed [MODEL_W-1:0]        my_in,
      input logic signed [NORM_W-1:0]         nx_in,
      input logic signed [NORM_W-1:0]         ny_in,
      input logic                             last_in
   );
      longint        cx, cy, c, s, mx, my, nx, ny, sx, sy;
      longint        px, py, vx, vy, dx, dy, ip;
      sq_type        dist_sq, norm_sq, ip_sq25, bound;
      logic          vis;
      placement_type p;
      cx = cx_in;
      cy = cy_in;
      c = cos_in;
      s = sin_in;
      mx = mx_in;
      my = my_in;
      nx = nx_in;
      ny = ny_in;
      sx = sensor_x[sel];
      sy = sensor_y[sel];
      px = clamp_coord(round_trig(c * mx - s * my) + cx);
      py = clamp_coord(round_trig(s * mx + c * my) + cy);
      vx = round_trig(c * nx - s * ny);
      vy = round_trig(s * nx + c * ny);
      dx = sx - px;
      dy = sy - py;
      dist_sq = dx * dx + dy * dy;
      norm_sq = vx * vx + vy * vy;
      ip = vx * dx + vy * dy;
      ip_sq25 = 25 * ip * ip;
      bound = norm_sq * dist_sq;
      if (dist_sq == 0 || norm_sq == 0) vis = 1'b0;
      else if (facing == MODE_HEAD) vis = (ip >= 0) || (ip_sq25 < bound);
      else vis = (ip > 0) && (ip_sq25 > bound);
      p.x = px[COORD_BITS:0];
      p.y = py[COORD_BITS:0];
      p.visible = vis;
      p.last = last_in;
      return p;
   endfunction

   always @(posedge clock) begin
      placement_type want, got;
      if (reset) begin
         sensor_x[0] = '0;
         sensor_y[0] = '0;
         sensor_x[1] = '0;
         sensor_y[1] = '0;
         facing = MODE_BODY;
         expected_placements.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SENSOR0_X: sensor_x[0] = csr_wdata[SENSOR_W-1:0];
               CSR_SENSOR0_Y: sensor_y[0] = csr_wdata[SENSOR_W-1:0];
               CSR_SENSOR1_X: sensor_x[1] = csr_wdata[SENSOR_W-1:0];
               CSR_SENSOR1_Y: sensor_y[1] = csr_wdata[SENSOR_W-1:0];
               CSR_FACING_MODE: facing = csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            expected_placements.insert(expected_placements.size(),
               predict_placement(req_center_x, req_center_y,
               req_rot_cos, req_rot_sin, req_sensor_sel, req_model_x, req_model_y,
               req_normal_x, req_normal_y, req_last_point));
         end
         if (rsp_valid) begin
            got.x = rsp_contour_x;
            got.y = rsp_contour_y;
            got.visible = rsp_visible;
            got.last = rsp_last_out;
            if (expected_placements.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result strobe with no transaction outstanding", $time);
            end else begin
               want = expected_placements.pop_front();
               checked_count++;
               if (want.visible) visible_count++;
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $write("%0t: placement mismatch: expected x=%0d y=%0d vis=%0b last=%0b",
                            $time, want.x, want.y, want.visible, want.last);
                     $display(", got x=%0d y=%0d vis=%0b last=%0b",
                              got.x, got.y, got.visible, got.last);
                  end
               end
            end
         end
      end
      mismatches <= fail_count;
      pending <= expected_placements.size();
      points_checked <= checked_count;
      visible_points <= visible_count;
   end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the contour point visibility core: clock, reset, sensor setup,
// directed and random contour point transactions, watchdog and verdict.
// Depends on cpv_pkg, contour_point_visibility_core and cpv_placement_checker.
`timescale 1ns / 1ps

module tb;
   import cpv_pkg::*;

   localparam int COORD_BITS = COORD_BITS_DEF;
   localparam int TRIG_W     = TRIG_FRAC_BITS_DEF + 2;
   localparam int LATENCY    = 10;
   localparam int QUIET_MAX  = 5000;

   typedef struct {
      logic        [CENTER_W-1:0] cx;
      logic        [CENTER_W-1:0] cy;
      logic signed [TRIG_W-1:0]   cos_v;
      logic signed [TRIG_W-1:0]   sin_v;
      logic                       sel;
      logic signed [MODEL_W-1:0]  mx;
      logic signed [MODEL_W-1:0]  my;
      logic signed [NORM_W-1:0]   nx;
      logic signed [NORM_W-1:0]   ny;
      logic                       last;
   } point_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic        [CENTER_W-1:0]  req_center_x = '0;
   logic        [CENTER_W-1:0]  req_center_y = '0;
   logic signed [TRIG_W-1:0]    req_rot_cos = '0;
   logic signed [TRIG_W-1:0]    req_rot_sin = '0;
   logic                        req_sensor_sel = 1'b0;
   logic signed [MODEL_W-1:0]   req_model_x = '0;
   logic signed [MODEL_W-1:0]   req_model_y = '0;
   logic signed [NORM_W-1:0]    req_normal_x = '0;
   logic signed [NORM_W-1:0]    req_normal_y = '0;
   logic                        req_last_point = 1'b0;
   logic                        rsp_valid;
   logic signed [COORD_BITS:0]  rsp_contour_x;
   logic signed [COORD_BITS:0]  rsp_contour_y;
   logic                        rsp_visible;
   logic                        rsp_last_out;
   logic                        csr_we = 1'b0;
   csr_idx_type                 csr_index = CSR_SENSOR0_X;
   logic        [CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatches, pending, points_checked, visible_points;
   int settings_applied = 0;
   int quiet_cycles = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   contour_point_visibility_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_rot_cos(req_rot_cos), .req_rot_sin(req_rot_sin),
      .req_sensor_sel(req_sensor_sel), .req_model_x(req_model_x),
      .req_model_y(req_model_y), .req_normal_x(req_normal_x),
      .req_normal_y(req_normal_y), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_contour_x(rsp_contour_x),
      .rsp_contour_y(rsp_contour_y), .rsp_visible(rsp_visible),
      .rsp_last_out(rsp_last_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   cpv_placement_checker placement_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_rot_cos(req_rot_cos), .req_rot_sin(req_rot_sin),
      .req_sensor_sel(req_sensor_sel), .req_model_x(req_model_x),
      .req_model_y(req_model_y), .req_normal_x(req_normal_x),
      .req_normal_y(req_normal_y), .req_last_point(req_last_point),
      .rsp_valid(rsp_valid), .rsp_contour_x(rsp_contour_x),
      .rsp_contour_y(rsp_contour_y), .rsp_visible(rsp_visible),
      .rsp_last_out(rsp_last_out),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatches(mismatches), .pending(pending),
      .points_checked(points_checked), .visible_points(visible_points)
   );

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
         $display("Watchdog: no transaction for %0d cycles", QUIET_MAX);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic point_type mk_point(input int cx, cy, c, s, sel, mx, my, nx, ny, last);
      point_type p;
      p.cx = CENTER_W'(cx);
      p.cy = CENTER_W'(cy);
      p.cos_v = TRIG_W'(c);
      p.sin_v = TRIG_W'(s);
      p.sel = sel[0];
      p.mx = MODEL_W'(mx);
      p.my = MODEL_W'(my);
      p.nx = NORM_W'(nx);
      p.ny = NORM_W'(ny);
      p.last = last[0];
      return p;
   endfunction

   // hold the transaction until the core takes it
   task automatic issue_point(input point_type p);
      req_center_x <= p.cx;
      req_center_y <= p.cy;
      req_rot_cos <= p.cos_v;
      req_rot_sin <= p.sin_v;
      req_sensor_sel <= p.sel;
      req_model_x <= p.mx;
      req_model_y <= p.my;
      req_normal_x <= p.nx;
      req_normal_y <= p.ny;
      req_last_point <= p.last;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_setup(input int s0x, s0y, s1x, s1y, input logic mode);
      csr_we <= 1'b1;
      csr_index <= CSR_SENSOR0_X;
      csr_wdata <= CSR_DATA_W'(s0x);
      @(posedge clock);
      csr_index <= CSR_SENSOR0_Y;
      csr_wdata <= CSR_DATA_W'(s0y);
      @(posedge clock);
      csr_index <= CSR_SENSOR1_X;
      csr_wdata <= CSR_DATA_W'(s1x);
      @(posedge clock);
      csr_index <= CSR_SENSOR1_Y;
      csr_wdata <= CSR_DATA_W'(s1y);
      @(posedge clock);
      csr_index <= CSR_FACING_MODE;
      csr_wdata <= CSR_DATA_W'(($urandom_range(2047) << 1) | mode);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   // hypotheses of random length sharing center, rotation and sensor
   task automatic run_hypotheses(input int n_points, input int idle_pct);
      point_type p;
      int        remain, run_len, gap, c, s;
      remain = n_points;
      while (remain > 0) begin
         p.cx = CENTER_W'($urandom_range(4095));
         p.cy = CENTER_W'($urandom_range(4095));
         p.sel = 1'($urandom_range(1));
         case ($urandom_range(9))
            0: begin
               p.cos_v = TRIG_W'($urandom);
               p.sin_v = TRIG_W'($urandom);
            end
            1: begin
               p.cos_v = TRIG_W'(16384);
               p.sin_v = '0;
            end
            default: begin
               c = int'($urandom_range(32768)) - 16384;
               s = $rtoi($sqrt(268435456.0 - c * c));
               if ($urandom_range(1)) s = -s;
               p.cos_v = TRIG_W'(c);
               p.sin_v = TRIG_W'(s);
            end
         endcase
         run_len = $urandom_range(16, 1);
         if (run_len > remain) run_len = remain;
         for (int k = 0; k < run_len; k++) begin
            if ($urandom_range(4) == 0) begin
               p.mx = MODEL_W'($urandom);
               p.my = MODEL_W'($urandom);
            end else begin
               p.mx = MODEL_W'(int'($urandom_range(600)) - 300);
               p.my = MODEL_W'(int'($urandom_range(600)) - 300);
            end
            case ($urandom_range(9))
               0: begin
                  p.nx = '0;
                  p.ny = '0;
               end
               1: begin
                  p.nx = '0;
                  p.ny = NORM_W'(int'($urandom_range(4000)) - 2000);
               end
               2, 3: begin
                  p.nx = NORM_W'($urandom);
                  p.ny = NORM_W'($urandom);
               end
               default: begin
                  p.nx = NORM_W'(int'($urandom_range(4000)) - 2000);
                  p.ny = NORM_W'(int'($urandom_range(4000)) - 2000);
               end
            endcase
            p.last = (k == run_len - 1);
            if ($urandom_range(19) == 0) p.last = !p.last;
            gap = 0;
            while ($urandom_range(99) < idle_pct) gap++;
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            issue_point(p);
         end
         remain -= run_len;
      end
      start <= 1'b0;
   endtask

   initial begin
      point_type directed [12];
      int        idle_pct;
      directed[0] = mk_point(1000, 1000, 16384, 0, 0, 0, 0, 5, 5, 0);
      directed[1] = mk_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      directed[2] = mk_point(4095, 4095, 16384, 16384, 1, 2047, -2048,
                             1073741823, -1073741824, 1);
      directed[3] = mk_point(4095, 4095, -32768, 32767, 0, -2048, -2048, 100, -100, 0);
      directed[4] = mk_point(0, 0, -32768, 32767, 1, 2047, 2047, -7, 3, 0);
      directed[5] = mk_point(2000, 2000, 8192, 0, 0, 3, 5, 1, 3, 0);
      directed[6] = mk_point(2000, 2000, 8192, 0, 0, -3, -5, -1, -3, 0);
      directed[7] = mk_point(2000, 2000, -8192, 8192, 1, 7, -9, 5, -11, 1);
      directed[8] = mk_point(4095, 2000, 16384, 0, 1, 0, 0, 1000, 0, 0);
      directed[9] = mk_point(0, 1000, 16384, 0, 0, 0, 0, -1, 0, 0);
      directed[10] = mk_point(0, 1000, 16384, 0, 0, 0, 0, -1, 10, 0);
      directed[11] = mk_point(0, 0, -32768, -32768, 1, -2048, 2047,
                              -1073741824, 1073741823, 1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_setup(1000, 1000, 4095, 0, MODE_BODY);
      foreach (directed[i]) issue_point(directed[i]);
      start <= 1'b0;
      drain();
      write_setup(1000, 1000, 4095, 0, MODE_HEAD);
      foreach (directed[i]) issue_point(directed[i]);
      start <= 1'b0;

      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph)
            0: write_setup(0, 0, 0, 0, MODE_BODY);
            1: write_setup(4095, 4095, 4095, 4095, MODE_HEAD);
            default: write_setup($urandom_range(4095), $urandom_range(4095),
                                 $urandom_range(4095), $urandom_range(4095), ph[0]);
         endcase
         idle_pct = (ph < 2) ? 12 : ((ph < 4) ? 82 : 0);
         run_hypotheses(255, idle_pct);
      end

      drain();
      repeat (3 * LATENCY) @(posedge clock);
      $display("Summary: %0d contour points checked over %0d sensor/mode settings, %0d visible",
               points_checked, settings_applied, visible_points);
      $display("Covered ties, saturation, zero magnitude, perpendicular and full-scale cases");
      if (pending != 0)
         $display("%0d expected placements never arrived", pending);
      if (mismatches == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
